### design/sset_pkg.sv
`default_nettype none
package sset_pkg;

  localparam int CAPACITY    = 64;
  localparam int VALUE_BITS  = 32;
  localparam int ADDR_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int KIND_W      = 2;
  localparam int COUNT_OUT_W = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_MEMBER = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_DELETE = 2'd2
  } kind_t;

  // flip the sign bit so unsigned order matches signed order
  function automatic logic [VALUE_BITS-1:0] order_key(input logic [VALUE_BITS-1:0] v);
    order_key = v ^ {1'b1, {(VALUE_BITS-1){1'b0}}};
  endfunction

endpackage
`default_nettype wire

### design/sset_ram.sv
`default_nettype none
module sset_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

### design/sorted_set_insert_delete_member_unit.sv
`default_nettype none
// sorted set of distinct signed values kept as order keys in one 1r1w synchronous ram
// states from accept to out_tvalid: search, decide, shift (successful insert or delete),
// key write (insert), done; the search reads one entry per cycle and a shift moves one
// entry per cycle
// throughput: one transaction at a time, the next is taken the cycle after the result is
// registered; reset: synchronous active-low rst_n empties the set, ram needs no clearing
module sorted_set_insert_delete_member_unit import sset_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] key_value
  input  wire logic [1:0]  in_tuser,   // [1:0] kind
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata   // [0] ok, [7:1] count_after
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SEARCH = 6'b000010,
    ST_DECIDE = 6'b000100,
    ST_SHIFT  = 6'b001000,
    ST_WKEY   = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [KIND_W-1:0]     kind_r, kind_nxt;
  logic [VALUE_BITS-1:0] key_r, key_nxt;
  logic [CNT_W-1:0]      issue_idx_r, issue_idx_nxt;
  logic                  cmp_vld_r, cmp_vld_nxt;
  logic [CNT_W-1:0]      cmp_idx_r, cmp_idx_nxt;
  logic [CNT_W-1:0]      pos_r, pos_nxt;
  logic                  hit_r, hit_nxt;
  logic                  ok_r, ok_nxt;
  logic [CNT_W-1:0]      sh_idx_r, sh_idx_nxt;
  logic [CNT_W-1:0]      lim_r, lim_nxt;
  logic                  more_r, more_nxt;
  logic                  pend_r, pend_nxt;
  logic [ADDR_W-1:0]     pend_addr_r, pend_addr_nxt;
  logic                  out_vld_r, out_vld_nxt;
  logic                  out_ok_r, out_ok_nxt;
  logic [CNT_W-1:0]      out_cnt_r, out_cnt_nxt;

  logic                  rd_en, wr_en;
  logic [ADDR_W-1:0]     rd_addr, wr_addr;
  logic [VALUE_BITS-1:0] rd_data, wr_data;
  logic                  is_insert;

  sset_ram #(.DEPTH(CAPACITY), .WIDTH(VALUE_BITS), .AW(ADDR_W)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {COUNT_OUT_W'(out_cnt_r), out_ok_r};
  assign is_insert  = (kind_r == KIND_INSERT);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    kind_nxt      = kind_r;
    key_nxt       = key_r;
    issue_idx_nxt = issue_idx_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    pos_nxt       = pos_r;
    hit_nxt       = hit_r;
    ok_nxt        = ok_r;
    sh_idx_nxt    = sh_idx_r;
    lim_nxt       = lim_r;
    more_nxt      = more_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    out_vld_nxt   = out_vld_r;
    out_ok_nxt    = out_ok_r;
    out_cnt_nxt   = out_cnt_r;
    rd_en         = 1'b0;
    rd_addr       = issue_idx_r[ADDR_W-1:0];
    wr_en         = 1'b0;
    wr_addr       = pend_addr_r;
    wr_data       = rd_data;

    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          kind_nxt      = in_tuser;
          key_nxt       = order_key(in_tdata[VALUE_BITS-1:0]);
          issue_idx_nxt = '0;
          state_nxt     = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        // reads issue back to back, each compare runs in the cycle after its read
        if (issue_idx_r < count_r) begin
          rd_en         = 1'b1;
          issue_idx_nxt = issue_idx_r + 1'b1;
          cmp_vld_nxt   = 1'b1;
          cmp_idx_nxt   = issue_idx_r;
        end
        if (count_r == '0) begin
          pos_nxt   = '0;
          hit_nxt   = 1'b0;
          state_nxt = ST_DECIDE;
        end else if (cmp_vld_r) begin
          if (rd_data >= key_r) begin
            pos_nxt   = cmp_idx_r;
            hit_nxt   = (rd_data == key_r);
            state_nxt = ST_DECIDE;
          end else if (CNT_W'(cmp_idx_r + 1'b1) == count_r) begin
            pos_nxt   = count_r;
            hit_nxt   = 1'b0;
            state_nxt = ST_DECIDE;
          end
        end
      end
      ST_DECIDE: begin
        ok_nxt    = 1'b0;
        pend_nxt  = 1'b0;
        state_nxt = ST_DONE;
        unique case (kind_r)
          KIND_MEMBER: begin
            ok_nxt = hit_r;
          end
          KIND_INSERT: begin
            if (!hit_r && (count_r < CNT_W'(CAPACITY))) begin
              ok_nxt     = 1'b1;
              sh_idx_nxt = count_r - 1'b1;
              lim_nxt    = pos_r;
              more_nxt   = (count_r != pos_r);
              state_nxt  = ST_SHIFT;
            end
          end
          KIND_DELETE: begin
            if (hit_r) begin
              ok_nxt     = 1'b1;
              count_nxt  = count_r - 1'b1;
              sh_idx_nxt = pos_r + 1'b1;
              lim_nxt    = count_r - 1'b1;
              more_nxt   = (CNT_W'(pos_r + 1'b1) != count_r);
              state_nxt  = ST_SHIFT;
            end
          end
          default: begin
            ok_nxt = 1'b0;
          end
        endcase
      end
      ST_SHIFT: begin
        // read entry i, write it one slot up (insert) or down (delete) in the next cycle
        if (pend_r) begin
          wr_en = 1'b1;
        end
        if (more_r) begin
          rd_en         = 1'b1;
          rd_addr       = sh_idx_r[ADDR_W-1:0];
          pend_nxt      = 1'b1;
          pend_addr_nxt = is_insert ? ADDR_W'(sh_idx_r + 1'b1) : ADDR_W'(sh_idx_r - 1'b1);
          sh_idx_nxt    = is_insert ? (sh_idx_r - 1'b1) : (sh_idx_r + 1'b1);
          more_nxt      = (sh_idx_r != lim_r);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = is_insert ? ST_WKEY : ST_DONE;
          end
        end
      end
      ST_WKEY: begin
        wr_en     = 1'b1;
        wr_addr   = pos_r[ADDR_W-1:0];
        wr_data   = key_r;
        count_nxt = count_r + 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt = 1'b1;
          out_ok_nxt  = ok_r;
          out_cnt_nxt = count_r;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      cmp_vld_r <= 1'b0;
      pend_r    <= 1'b0;
      more_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      pend_r    <= pend_nxt;
      more_r    <= more_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    key_r       <= key_nxt;
    issue_idx_r <= issue_idx_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    pos_r       <= pos_nxt;
    hit_r       <= hit_nxt;
    ok_r        <= ok_nxt;
    sh_idx_r    <= sh_idx_nxt;
    lim_r       <= lim_nxt;
    pend_addr_r <= pend_addr_nxt;
    out_ok_r    <= out_ok_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("stored count above capacity");

  a_no_write_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_SEARCH || state_r == ST_DONE) |-> !wr_en)
    else $error("ram write outside shift or key write");

  a_wkey_increments: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WKEY) |=> (count_r == CNT_W'($past(count_r) + 1'b1)))
    else $error("insert did not advance count");

  a_accept_starts_search: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_SEARCH))
    else $error("accepted transaction did not start search");

endmodule
`default_nettype wire
